>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> hw/rtl/ewrm_pkg.sv
// ----------------------------------------------------------------------------
// ewrm_pkg
// Shared constants and types of the event window rate and energy monitor.
// ----------------------------------------------------------------------------
package ewrm_pkg;

  localparam logic [7:0] REG_WINDOW_LEN    = 8'd0;
  localparam logic [7:0] REG_DEAD_MODE     = 8'd1;
  localparam logic [7:0] REG_ENERGY_SOURCE = 8'd2;
  localparam logic [7:0] REG_ENERGY_GAIN   = 8'd3;

  localparam logic [7:0]  WINDOW_LEN_RST  = 8'd100;
  localparam logic [15:0] ENERGY_GAIN_RST = 16'd3211;

  localparam logic [63:0] MS_PER_S   = 64'd1000;
  localparam logic [63:0] RATE_SCALE = MS_PER_S << 16;
  localparam logic [63:0] RATE_MAX   = (64'd1 << 40) - 64'd1;
  localparam logic [63:0] ESUM_MAX   = (64'd1 << 35) - 64'd1;

  localparam int unsigned FAULT_HIGH = 800;
  localparam int unsigned FAULT_LOW  = 15;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> hw/rtl/ewrm_ram.sv
// ----------------------------------------------------------------------------
// ewrm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ewrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/ewrm_div.sv
// ----------------------------------------------------------------------------
// ewrm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ewrm_div import ewrm_pkg::*; #(
  parameter int NW = 34,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output div_stat_t     stat,
  output logic [NW-1:0] quo
);

  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;
  logic [DW:0]   trial;
  logic          take;

  assign trial = {rem, quo[NW-1]};
  assign take  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= num;
      den_r <= den;
    end else if (busy) begin
      rem <= take ? DW'(trial - {1'b0, den_r}) : DW'(trial);
      quo <= {quo[NW-2:0], take};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

>>> hw/rtl/event_window_rate_energy_monitor_top.sv
// ----------------------------------------------------------------------------
// event_window_rate_energy_monitor_top
// Sliding-window event rate, energy sum and energy maximum over detector events.
// ----------------------------------------------------------------------------
// One event is processed at a time. An event that leaves the window not yet
// full passes only through S_RDO, S_WR and S_FIN. With a full window the energy
// maximum is found by rescanning the window through the single read port of
// the event memory (one entry per cycle), and the rate comes from a
// bit-serial divider producing NUM_W quotient bits (33 at MAX_WINDOW = 128).
// A finished result sits in the output register while the next event is
// accepted.
module event_window_rate_energy_monitor_top import ewrm_pkg::*; #(
  parameter int MAX_WINDOW = 128,
  parameter int ADC_BITS   = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [7:0]             cfg_index,
  input  logic [15:0]            cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [31:0]            live_stamp_ms,
  input  logic [31:0]            dead_value_ms,
  input  logic [ADC_BITS-1:0]    pulse_area,
  input  logic [ADC_BITS-1:0]    pulse_peak,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   window_full,
  output logic [31:0]            middle_stamp_ms,
  output logic [39:0]            event_rate,
  output logic                   rate_valid,
  output logic [34:0]            energy_sum,
  output logic [ADC_BITS+15:0]   energy_max,
  output logic                   pulse_fault
);

`include "assert_macros.svh"

  localparam int PW    = $clog2(MAX_WINDOW);
  localparam int LW    = $clog2(MAX_WINDOW + 1);
  localparam int EW    = ADC_BITS + 16;
  localparam int ESW   = EW + LW;
  localparam int DSW   = 32 + LW;
  localparam int SW    = DSW + 1;
  localparam int MW    = 64 + EW;
  localparam longint NUM_MAX = longint'(MAX_WINDOW) * 64'd65536000;
  localparam int NUM_W = $clog2(NUM_MAX + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RDO    = 4'd1;
  localparam logic [3:0] S_WR     = 4'd2;
  localparam logic [3:0] S_RDA    = 4'd3;
  localparam logic [3:0] S_RDM    = 4'd4;
  localparam logic [3:0] S_SCAN   = 4'd5;
  localparam logic [3:0] S_LAST   = 4'd6;
  localparam logic [3:0] S_DSTART = 4'd7;
  localparam logic [3:0] S_DWAIT  = 4'd8;
  localparam logic [3:0] S_FIN    = 4'd9;

  // configuration
  logic [7:0]  window_len;
  logic        dead_mode;
  logic        energy_source;
  logic [15:0] energy_gain;

  // window state
  logic [3:0]     state;
  logic [PW-1:0]  wp;
  logic [LW-1:0]  fill_count;
  logic [DSW-1:0] dead_sum;
  logic [ESW-1:0] esum;

  // current event
  logic [31:0]    live_r;
  logic [31:0]    dead_r;
  logic [EW-1:0]  energy_r;
  logic           fault_r;
  logic           full_before;
  logic           full_now;

  // window evaluation
  logic [PW-1:0]  oldest_p;
  logic [PW-1:0]  scan_addr;
  logic [LW-1:0]  cnt;
  logic [31:0]    stamp_mid;
  logic [31:0]    live_span;
  logic [31:0]    dead_diff;
  logic [EW-1:0]  emax;
  logic [NUM_W-1:0] num_r;
  logic [31:0]    span_r;
  logic           span_pos;

  logic [LW-1:0]  len;
  logic [ADC_BITS-1:0] adc;
  logic           fault;
  logic [PW+1:0]  evict_t;
  logic [PW+1:0]  oldest_t;
  logic [PW+1:0]  mid_t;
  logic [PW-1:0]  evict_addr;
  logic [PW-1:0]  oldest_addr;
  logic [PW-1:0]  mid_addr;
  logic [PW-1:0]  scan_next;
  logic [PW-1:0]  wp_inc;
  logic [PW-1:0]  raddr;
  logic           we;
  logic [MW-1:0]  rdata;
  logic [31:0]    rd_stamp;
  logic [31:0]    rd_dead;
  logic [EW-1:0]  rd_energy;
  logic [DSW-1:0] dead_span;
  logic [SW-1:0]  span;
  logic [LW-1:0]  fill_next;
  logic           div_start;
  div_stat_t      div_stat;
  logic [NUM_W-1:0] quo;
  logic [63:0]    quo_ext;
  logic [63:0]    esum_ext;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    if (window_len < 8'd2) begin
      len = LW'(2);
    end else if (32'(window_len) > 32'(MAX_WINDOW)) begin
      len = LW'(MAX_WINDOW);
    end else begin
      len = LW'(window_len);
    end
  end

  assign adc   = energy_source ? pulse_peak : pulse_area;
  assign fault = (pulse_peak < adc) &&
                 (32'(pulse_peak) < FAULT_HIGH || 32'(pulse_area) < FAULT_HIGH) &&
                 (32'(pulse_peak) > FAULT_LOW  || 32'(pulse_area) > FAULT_LOW);

  // ring address arithmetic modulo MAX_WINDOW
  assign evict_t  = (PW+2)'(wp) + (PW+2)'(MAX_WINDOW) - (PW+2)'(len);
  assign oldest_t = evict_t;
  assign mid_t    = (PW+2)'(oldest_p) + (PW+2)'(len >> 1);
  assign evict_addr  = (evict_t  >= (PW+2)'(MAX_WINDOW)) ?
                       PW'(evict_t  - (PW+2)'(MAX_WINDOW)) : PW'(evict_t);
  assign oldest_addr = (oldest_t >= (PW+2)'(MAX_WINDOW)) ?
                       PW'(oldest_t - (PW+2)'(MAX_WINDOW)) : PW'(oldest_t);
  assign mid_addr    = (mid_t    >= (PW+2)'(MAX_WINDOW)) ?
                       PW'(mid_t    - (PW+2)'(MAX_WINDOW)) : PW'(mid_t);
  assign wp_inc    = (wp == PW'(MAX_WINDOW - 1)) ? '0 : wp + PW'(1);
  assign scan_next = (scan_addr == PW'(MAX_WINDOW - 1)) ? '0 : scan_addr + PW'(1);

  always_comb begin
    case (state)
      S_RDO:   raddr = evict_addr;
      S_RDA:   raddr = oldest_addr;
      S_RDM:   raddr = mid_addr;
      S_SCAN:  raddr = scan_addr;
      default: raddr = scan_addr;
    endcase
  end

  assign we = (state == S_WR);

  ewrm_ram #(
    .WIDTH(MW),
    .DEPTH(MAX_WINDOW)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(wp),
    .wdata({live_r, dead_r, energy_r}),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign rd_stamp  = rdata[MW-1 -: 32];
  assign rd_dead   = rdata[EW+31 -: 32];
  assign rd_energy = rdata[EW-1:0];

  assign fill_next = full_before ? len : fill_count + LW'(1);
  assign dead_span = dead_mode ? dead_sum : DSW'(dead_diff);
  assign span      = SW'(live_span) - SW'(dead_span);
  assign div_start = (state == S_DSTART) && span_pos;

  ewrm_div #(
    .NW(NUM_W),
    .DW(32)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (num_r),
    .den  (span_r),
    .stat (div_stat),
    .quo  (quo)
  );

  assign quo_ext  = 64'(quo);
  assign esum_ext = 64'(esum);

  // control and window state
  always_ff @(posedge clk) begin
    if (rst) begin
      window_len    <= WINDOW_LEN_RST;
      dead_mode     <= 1'b0;
      energy_source <= 1'b0;
      energy_gain   <= ENERGY_GAIN_RST;
      state         <= S_IDLE;
      wp            <= '0;
      fill_count    <= '0;
      dead_sum      <= '0;
      esum          <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WINDOW_LEN: begin
            window_len <= cfg_data[7:0];
            wp         <= '0;
            fill_count <= '0;
            dead_sum   <= '0;
            esum       <= '0;
          end
          REG_DEAD_MODE:     dead_mode     <= cfg_data[0];
          REG_ENERGY_SOURCE: energy_source <= cfg_data[0];
          REG_ENERGY_GAIN:   energy_gain   <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_RDO;
          end
        end
        S_RDO: state <= S_WR;
        S_WR: begin
          // rdata holds the evicted entry read last cycle
          dead_sum   <= dead_sum - (full_before ? DSW'(rd_dead) : '0) + DSW'(dead_r);
          esum       <= esum - (full_before ? ESW'(rd_energy) : '0) + ESW'(energy_r);
          fill_count <= fill_next;
          wp         <= wp_inc;
          state      <= (fill_next == len) ? S_RDA : S_FIN;
        end
        S_RDA: state <= S_RDM;
        S_RDM: state <= S_SCAN;
        S_SCAN: begin
          if (cnt == len - LW'(1)) begin
            state <= S_LAST;
          end
        end
        S_LAST:   state <= S_DSTART;
        S_DSTART: state <= span_pos ? S_DWAIT : S_FIN;
        S_DWAIT: begin
          if (div_stat.done) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        live_r      <= live_stamp_ms;
        dead_r      <= dead_value_ms;
        energy_r    <= EW'(adc) * EW'(energy_gain);
        fault_r     <= fault;
        full_before <= fill_count >= len;
      end
      S_WR:  full_now <= (fill_next == len);
      S_RDA: oldest_p <= oldest_addr;
      S_RDM: begin
        live_span <= live_r - rd_stamp;
        dead_diff <= dead_r - rd_dead;
        scan_addr <= oldest_p;
        cnt       <= '0;
      end
      S_SCAN: begin
        scan_addr <= scan_next;
        cnt       <= cnt + LW'(1);
        if (cnt == '0) begin
          stamp_mid <= rd_stamp;
          emax      <= '0;
        end else if (rd_energy > emax) begin
          emax <= rd_energy;
        end
      end
      S_LAST: begin
        if (rd_energy > emax) begin
          emax <= rd_energy;
        end
        span_pos <= !span[SW-1] && (span != '0);
        span_r   <= span[31:0];
        num_r    <= NUM_W'(64'(len) * RATE_SCALE);
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          window_full     <= full_now;
          pulse_fault     <= fault_r;
          middle_stamp_ms <= full_now ? stamp_mid : '0;
          energy_max      <= full_now ? emax : '0;
          energy_sum      <= !full_now ? '0 :
                             (esum_ext > ESUM_MAX) ? 35'(ESUM_MAX) : 35'(esum);
          rate_valid      <= full_now && span_pos;
          event_rate      <= !(full_now && span_pos) ? '0 :
                             (quo_ext > RATE_MAX) ? 40'(RATE_MAX) : 40'(quo);
        end
      end
      default: ;
    endcase
  end

  `ASSERT_ALWAYS(a_fill_le_len, fill_count <= len, "fill count exceeds window length")
  `ASSERT_ALWAYS(a_wp_range, 32'(wp) < 32'(MAX_WINDOW), "write pointer out of ring")
  `ASSERT_IMPLY(a_div_idle, div_start, !div_stat.busy, "divider started while busy")

endmodule
